@@ rtl/core/text_console_cell_writer_core_macros.svh @@
// Assertion macros for the text console cell writer RTL.
`ifndef TEXT_CONSOLE_CELL_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TCW_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/tcw_pkg.sv @@
// Shared types, codes and helpers for the text console cell writer.
package tcw_pkg;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 11;
    localparam int CNT_W  = 4;
    localparam int NUM_DIGITS = 10;

    localparam logic [1:0] ACT_CHAR = 2'd0;
    localparam logic [1:0] ACT_HEX  = 2'd1;
    localparam logic [1:0] ACT_DEC  = 2'd2;

    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_NEWLINE = 2'd1;
    localparam logic [1:0] KIND_HEX     = 2'd2;
    localparam logic [1:0] KIND_DEC     = 2'd3;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_X       = 8'h78;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;

    localparam logic [0:0] REG_FG_COLOR = 1'b0;
    localparam logic [0:0] REG_BG_COLOR = 1'b1;

    // ceil(2^35 / 10); quotient = (v * RECIP10) >> 35 for any 32-bit v
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  ch;
        logic [31:0] value;
    } cmd_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = CHAR_ZERO + {4'b0, nib};
        end
        else
        begin
            c = CHAR_UPPER_A + {4'b0, nib - 4'd10};
        end
        return c;
    endfunction

endpackage

@@ rtl/core/tcw_front.sv @@
// Front end: accepts input transactions, classifies them and queues commands.
module tcw_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [1:0]       action,
    input  logic [7:0]       char_code,
    input  logic [31:0]      value,
    output tcw_pkg::cmd_t    cmd,
    output logic             cmd_valid,
    input  logic             cmd_pop
);

    tcw_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    tcw_pkg::cmd_t new_cmd;
    logic          keep;
    logic          accept;
    logic          do_write;
    logic          do_read;

    always_comb
    begin
        new_cmd.ch    = char_code;
        new_cmd.value = value;
        new_cmd.kind  = tcw_pkg::KIND_CHAR;
        keep          = 1'b0;
        unique case (action)
            tcw_pkg::ACT_CHAR:
            begin
                if (char_code == tcw_pkg::CHAR_NEWLINE)
                begin
                    new_cmd.kind = tcw_pkg::KIND_NEWLINE;
                    keep         = 1'b1;
                end
                else if (char_code != tcw_pkg::CHAR_NUL)
                begin
                    new_cmd.kind = tcw_pkg::KIND_CHAR;
                    keep         = 1'b1;
                end
            end
            tcw_pkg::ACT_HEX:
            begin
                new_cmd.kind = tcw_pkg::KIND_HEX;
                keep         = 1'b1;
            end
            tcw_pkg::ACT_DEC:
            begin
                new_cmd.kind = tcw_pkg::KIND_DEC;
                keep         = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign full      = (count_reg == 2'd2);
    assign accept    = push && !full;
    assign do_write  = accept && keep;
    assign cmd_valid = (count_reg != 2'd0);
    assign do_read   = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_write;
        rd_ptr_next = rd_ptr_reg ^ do_read;
        count_next  = count_reg;
        if (do_write && !do_read)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_write && do_read)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

@@ rtl/core/tcw_back.sv @@
// Back end: runs queued commands, keeps the cursor and drives the cell write queue.
`include "text_console_cell_writer_core_macros.svh"

module tcw_back
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  tcw_pkg::cmd_t               cmd,
    input  logic                        cmd_valid,
    output logic                        cmd_pop,
    input  logic [7:0]                  attr,
    output logic                        empty,
    input  logic                        pop,
    output logic [tcw_pkg::ADDR_W-1:0]  cell_address,
    output logic [15:0]                 cell_word,
    output logic                        last
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_HEX      = 3'd1;
    localparam logic [2:0] S_DEC_MUL  = 3'd2;
    localparam logic [2:0] S_DEC_SUB  = 3'd3;
    localparam logic [2:0] S_DEC_EMIT = 3'd4;

    localparam logic [tcw_pkg::COL_W-1:0]  COL_LAST = tcw_pkg::COL_W'(COLUMNS - 1);
    localparam logic [tcw_pkg::ROW_W-1:0]  ROW_LAST = tcw_pkg::ROW_W'(ROWS - 1);
    localparam logic [tcw_pkg::ADDR_W-1:0] COLS_A   = tcw_pkg::ADDR_W'(COLUMNS);

    logic [2:0]                  state_reg, state_next;
    logic [31:0]                 val_reg, val_next;
    logic [tcw_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [63:0]                 prod_reg, prod_next;
    logic [3:0]                  digit_reg [tcw_pkg::NUM_DIGITS];
    logic [tcw_pkg::COL_W-1:0]   col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0]   row_reg, row_next;
    logic                        out_valid_reg, out_valid_next;
    logic [tcw_pkg::ADDR_W-1:0]  out_addr_reg;
    logic [15:0]                 out_word_reg;
    logic                        out_last_reg;

    logic                        can_emit;
    logic                        emit;
    logic [7:0]                  emit_char;
    logic                        emit_last;
    logic                        newline;
    logic                        digit_we;
    logic [3:0]                  digit_wdata;
    logic [tcw_pkg::CNT_W-1:0]   dig_idx;
    logic [28:0]                 quo;
    logic [31:0]                 quo_x10;
    logic [tcw_pkg::ADDR_W-1:0]  cur_addr;

    assign can_emit = !out_valid_reg || pop;
    assign quo      = prod_reg[63:35];
    assign quo_x10  = {quo, 3'b000} + {2'b00, quo, 1'b0};
    assign dig_idx  = cnt_reg - tcw_pkg::CNT_W'(1);
    assign cur_addr = tcw_pkg::ADDR_W'(row_reg) * COLS_A + tcw_pkg::ADDR_W'(col_reg);

    always_comb
    begin
        state_next  = state_reg;
        val_next    = val_reg;
        cnt_next    = cnt_reg;
        prod_next   = prod_reg;
        cmd_pop     = 1'b0;
        emit        = 1'b0;
        emit_char   = tcw_pkg::CHAR_NUL;
        emit_last   = 1'b0;
        newline     = 1'b0;
        digit_we    = 1'b0;
        digit_wdata = 4'd0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        tcw_pkg::KIND_CHAR:
                        begin
                            if (can_emit)
                            begin
                                cmd_pop   = 1'b1;
                                emit      = 1'b1;
                                emit_char = cmd.ch;
                                emit_last = 1'b1;
                            end
                        end
                        tcw_pkg::KIND_NEWLINE:
                        begin
                            cmd_pop = 1'b1;
                            newline = 1'b1;
                        end
                        tcw_pkg::KIND_HEX:
                        begin
                            cmd_pop    = 1'b1;
                            val_next   = cmd.value;
                            cnt_next   = '0;
                            state_next = S_HEX;
                        end
                        tcw_pkg::KIND_DEC:
                        begin
                            cmd_pop    = 1'b1;
                            val_next   = cmd.value;
                            cnt_next   = '0;
                            state_next = S_DEC_MUL;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_HEX:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    if (cnt_reg == tcw_pkg::CNT_W'(0))
                    begin
                        emit_char = tcw_pkg::CHAR_ZERO;
                    end
                    else if (cnt_reg == tcw_pkg::CNT_W'(1))
                    begin
                        emit_char = tcw_pkg::CHAR_X;
                    end
                    else
                    begin
                        emit_char = tcw_pkg::hex_char(val_reg[31:28]);
                        val_next  = {val_reg[27:0], 4'b0000};
                    end
                    emit_last = (cnt_reg == tcw_pkg::CNT_W'(9));
                    cnt_next  = cnt_reg + tcw_pkg::CNT_W'(1);
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DEC_MUL:
            begin
                prod_next  = {32'b0, val_reg} * {32'b0, tcw_pkg::RECIP10};
                state_next = S_DEC_SUB;
            end
            S_DEC_SUB:
            begin
                digit_we    = 1'b1;
                digit_wdata = val_reg[3:0] - quo_x10[3:0];
                cnt_next    = cnt_reg + tcw_pkg::CNT_W'(1);
                val_next    = {3'b000, quo};
                state_next  = (quo == 29'd0) ? S_DEC_EMIT : S_DEC_MUL;
            end
            S_DEC_EMIT:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_char = tcw_pkg::CHAR_ZERO + {4'b0, digit_reg[dig_idx]};
                    emit_last = (cnt_reg == tcw_pkg::CNT_W'(1));
                    cnt_next  = dig_idx;
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (emit)
        begin
            if (col_reg == COL_LAST)
            begin
                col_next = '0;
                if (row_reg != ROW_LAST)
                begin
                    row_next = row_reg + tcw_pkg::ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + tcw_pkg::COL_W'(1);
            end
        end
        else if (newline)
        begin
            col_next = '0;
            if (row_reg != ROW_LAST)
            begin
                row_next = row_reg + tcw_pkg::ROW_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        prod_reg <= prod_next;
        if (digit_we)
        begin
            digit_reg[cnt_reg] <= digit_wdata;
        end
        if (emit)
        begin
            out_addr_reg <= cur_addr;
            out_word_reg <= {attr, emit_char};
            out_last_reg <= emit_last;
        end
    end

    assign empty        = !out_valid_reg;
    assign cell_address = out_addr_reg;
    assign cell_word    = out_word_reg;
    assign last         = out_last_reg;

    `TCW_ASSERT_HOLDS(a_row_bound, 1'b1, row_reg <= ROW_LAST, "cursor row past last row")
    `TCW_ASSERT_HOLDS(a_col_bound, 1'b1, col_reg <= COL_LAST, "cursor column past last column")
    `TCW_ASSERT_HOLDS(a_dec_count, state_reg == S_DEC_EMIT, cnt_reg != '0, "decimal emit with no digits")
    `TCW_ASSERT_NEXT(a_last_idle, emit && emit_last, state_reg == S_IDLE, "sequencer busy after last cell")

endmodule

@@ rtl/core/text_console_cell_writer_core.sv @@
// Top level of the text console cell writer: color registers, front end and back end.
// Each input transaction is a character, a 32-bit value printed as 0x plus eight hex
// digits, or a value printed in decimal; every printed character comes out as one cell
// write (address, word, last) on the result queue, and a newline moves the cursor
// without output. Queued commands run in the back end: a hex print and the digits of a
// decimal print come out at one cell per cycle while the output register is free or
// being popped; a decimal print first finds its digits with a reciprocal multiply and
// remainder step per digit. A two-entry command queue lets new transactions be taken
// while the back end works, and a one-entry output register holds a result until it is
// popped. Color writes apply to later cells.
module text_console_cell_writer_core
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  action,
    input  logic [7:0]                  char_code,
    input  logic [31:0]                 value,
    output logic                        empty,
    input  logic                        pop,
    output logic [tcw_pkg::ADDR_W-1:0]  cell_address,
    output logic [15:0]                 cell_word,
    output logic                        last,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [3:0]                  cfg_wdata
);

    logic [3:0]    fg_color_reg, fg_color_next;
    logic [3:0]    bg_color_reg, bg_color_next;
    tcw_pkg::cmd_t cmd;
    logic          cmd_valid;
    logic          cmd_pop;

    always_comb
    begin
        fg_color_next = fg_color_reg;
        bg_color_next = bg_color_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                tcw_pkg::REG_FG_COLOR: fg_color_next = cfg_wdata;
                tcw_pkg::REG_BG_COLOR: bg_color_next = cfg_wdata;
                default:               fg_color_next = fg_color_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_color_reg <= 4'hF;
            bg_color_reg <= 4'h0;
        end
        else
        begin
            fg_color_reg <= fg_color_next;
            bg_color_reg <= bg_color_next;
        end
    end

    tcw_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .action    (action),
        .char_code (char_code),
        .value     (value),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    tcw_back
    #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop),
        .attr         ({bg_color_reg, fg_color_reg}),
        .empty        (empty),
        .pop          (pop),
        .cell_address (cell_address),
        .cell_word    (cell_word),
        .last         (last)
    );

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for text_console_cell_writer_core: cursor and cell-word predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_GAP      = 17;
    localparam int PHASE_ITEMS  = 30;
    localparam int NUM_PHASES   = 5;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [tcw_pkg::ADDR_W-1:0] addr;
        logic [15:0]                word;
        logic                       fin;
    } cell_t;

    class cell_write_board;
        logic [3:0]  fg;
        logic [3:0]  bg;
        int unsigned col;
        int unsigned row;
        cell_t       pending_cells[$];
        int unsigned errors;
        int unsigned cells_checked;
        int unsigned n_char;
        int unsigned n_newline;
        int unsigned n_hex;
        int unsigned n_dec;
        int unsigned n_ignored;

        function new();
            fg = 4'hF;
            bg = 4'h0;
            col = 0;
            row = 0;
            errors = 0;
            cells_checked = 0;
            n_char = 0;
            n_newline = 0;
            n_hex = 0;
            n_dec = 0;
            n_ignored = 0;
        endfunction

        function void set_color(logic [0:0] idx, logic [3:0] data);
            if (idx == tcw_pkg::REG_FG_COLOR)
            begin
                fg = data;
            end
            else
            begin
                bg = data;
            end
        endfunction

        function void next_row();
            if (row < ROWS - 1)
            begin
                row++;
            end
        endfunction

        function void put_cell(logic [7:0] ch);
            cell_t c;
            int unsigned a;
            a = row * COLUMNS + col;
            c.addr = a[tcw_pkg::ADDR_W-1:0];
            c.word = {bg, fg, ch};
            c.fin = 1'b0;
            pending_cells.push_back(c);
            col++;
            if (col >= COLUMNS)
            begin
                col = 0;
                next_row();
            end
        endfunction

        function void note_item(logic [1:0] act, logic [7:0] ch, logic [31:0] val);
            int         start;
            int         n;
            logic [3:0] nib;
            logic [3:0] digits [10];
            logic [31:0] v;
            cell_t      c;
            start = pending_cells.size();
            case (act)
                tcw_pkg::ACT_CHAR:
                begin
                    if (ch == tcw_pkg::CHAR_NEWLINE)
                    begin
                        col = 0;
                        next_row();
                        n_newline++;
                    end
                    else if (ch != tcw_pkg::CHAR_NUL)
                    begin
                        put_cell(ch);
                        n_char++;
                    end
                    else
                    begin
                        n_ignored++;
                    end
                end
                tcw_pkg::ACT_HEX:
                begin
                    put_cell(tcw_pkg::CHAR_ZERO);
                    put_cell(tcw_pkg::CHAR_X);
                    for (int i = 7; i >= 0; i--)
                    begin
                        nib = val[i*4 +: 4];
                        if (nib < 4'd10)
                        begin
                            put_cell(tcw_pkg::CHAR_ZERO + {4'b0, nib});
                        end
                        else
                        begin
                            put_cell(tcw_pkg::CHAR_UPPER_A + {4'b0, nib} - 8'd10);
                        end
                    end
                    n_hex++;
                end
                tcw_pkg::ACT_DEC:
                begin
                    v = val;
                    n = 0;
                    if (v == 32'd0)
                    begin
                        digits[0] = 4'd0;
                        n = 1;
                    end
                    else
                    begin
                        while (v != 32'd0)
                        begin
                            digits[n] = 4'(v % 32'd10);
                            v = v / 32'd10;
                            n++;
                        end
                    end
                    while (n > 0)
                    begin
                        n--;
                        put_cell(tcw_pkg::CHAR_ZERO + {4'b0, digits[n]});
                    end
                    n_dec++;
                end
                default:
                begin
                    n_ignored++;
                end
            endcase
            if (pending_cells.size() > start)
            begin
                c = pending_cells.pop_back();
                c.fin = 1'b1;
                pending_cells.push_back(c);
            end
        endfunction

        function void check_cell(logic [tcw_pkg::ADDR_W-1:0] addr, logic [15:0] word,
                                 logic fin);
            cell_t e;
            if (pending_cells.size() == 0)
            begin
                $error("cell write with nothing pending: address %0d word %h", addr, word);
                errors++;
                return;
            end
            e = pending_cells.pop_front();
            cells_checked++;
            if (addr !== e.addr)
            begin
                $error("cell_address: expected %0d, actual %0d", e.addr, addr);
                errors++;
            end
            if (word !== e.word)
            begin
                $error("cell_word: expected %h, actual %h", e.word, word);
                errors++;
            end
            if (fin !== e.fin)
            begin
                $error("last: expected %0b, actual %0b", e.fin, fin);
                errors++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic [1:0]                 action;
    logic [7:0]                 char_code;
    logic [31:0]                value;
    logic                       empty;
    logic                       pop;
    logic [tcw_pkg::ADDR_W-1:0] cell_address;
    logic [15:0]                cell_word;
    logic                       last;
    logic                       cfg_we;
    logic [0:0]                 cfg_index;
    logic [3:0]                 cfg_wdata;

    cell_write_board board;
    bit              send_gaps;
    bit              recv_gaps;
    int unsigned     color_settings;

    text_console_cell_writer_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .action       (action),
        .char_code    (char_code),
        .value        (value),
        .empty        (empty),
        .pop          (pop),
        .cell_address (cell_address),
        .cell_word    (cell_word),
        .last         (last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] pick_number();
        logic [31:0] n;
        case ($urandom_range(0, 5))
            0: n = 32'd0;
            1: n = 32'hFFFF_FFFF;
            2: n = $urandom_range(0, 9);
            3: n = $urandom_range(0, 99999);
            default: n = $urandom;
        endcase
        return n;
    endfunction

    task automatic send_item(input logic [1:0] a, input logic [7:0] c, input logic [31:0] v);
        int   gap;
        logic f;
        gap = send_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        action <= a;
        char_code <= c;
        value <= v;
        do
        begin
            @(negedge clk);
            f = full;
            @(posedge clk);
        end
        while (f);
        board.note_item(a, c, v);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (board.pending_cells.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_color(input logic [0:0] idx, input logic [3:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_color(idx, data);
    endtask

    task automatic send_number();
        if ($urandom_range(0, 1) == 0)
        begin
            send_item(tcw_pkg::ACT_HEX, 8'($urandom), $urandom);
        end
        else
        begin
            send_item(tcw_pkg::ACT_DEC, 8'($urandom), pick_number());
        end
    endtask

    task automatic run_directed();
        send_item(tcw_pkg::ACT_CHAR, tcw_pkg::CHAR_UPPER_A, 32'hFFFF_FFFF);
        send_item(tcw_pkg::ACT_CHAR, 8'hFF, 32'd0);
        send_item(tcw_pkg::ACT_CHAR, 8'h01, $urandom);
        send_item(tcw_pkg::ACT_CHAR, tcw_pkg::CHAR_NUL, $urandom);
        send_item(tcw_pkg::ACT_CHAR, tcw_pkg::CHAR_NEWLINE, $urandom);
        // eight hex prints fill one row exactly and wrap
        send_item(tcw_pkg::ACT_HEX, 8'hFF, 32'd0);
        send_item(tcw_pkg::ACT_HEX, 8'h00, 32'hFFFF_FFFF);
        send_item(tcw_pkg::ACT_HEX, 8'($urandom), 32'h0123_4567);
        send_item(tcw_pkg::ACT_HEX, 8'($urandom), 32'h89AB_CDEF);
        repeat (4) send_item(tcw_pkg::ACT_HEX, 8'($urandom), $urandom);
        send_item(tcw_pkg::ACT_DEC, 8'($urandom), 32'd0);
        send_item(tcw_pkg::ACT_DEC, 8'($urandom), 32'hFFFF_FFFF);
        send_item(tcw_pkg::ACT_DEC, 8'($urandom), 32'd9);
        send_item(tcw_pkg::ACT_DEC, 8'($urandom), 32'd10);
        send_item(tcw_pkg::ACT_DEC, 8'($urandom), 32'd1_000_000_000);
        send_item(ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF);
        send_item(tcw_pkg::ACT_CHAR, 8'h80, 32'hFFFF_FFFF);
        send_item(tcw_pkg::ACT_CHAR, tcw_pkg::CHAR_NEWLINE, 32'd0);
        send_item(tcw_pkg::ACT_CHAR, 8'h7F, $urandom);
    endtask

    task automatic run_random(input int count);
        int done;
        int roll;
        int burst;
        done = 0;
        while (done < count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
            begin
                burst = $urandom_range(5, 30);
                if (burst > count - done)
                begin
                    burst = count - done;
                end
                repeat (burst) send_item(tcw_pkg::ACT_CHAR, tcw_pkg::CHAR_NEWLINE, $urandom);
                done += burst;
            end
            else if (roll < 6)
            begin
                burst = $urandom_range(8, 12);
                if (burst > count - done)
                begin
                    burst = count - done;
                end
                repeat (burst) send_number();
                done += burst;
            end
            else if (roll < 40)
            begin
                send_item(tcw_pkg::ACT_CHAR, 8'($urandom_range(1, 255)), $urandom);
                done++;
            end
            else if (roll < 55)
            begin
                send_item(tcw_pkg::ACT_CHAR, tcw_pkg::CHAR_NEWLINE, $urandom);
                done++;
            end
            else if (roll < 70)
            begin
                send_item(tcw_pkg::ACT_HEX, 8'($urandom), $urandom);
                done++;
            end
            else if (roll < 88)
            begin
                send_item(tcw_pkg::ACT_DEC, 8'($urandom), pick_number());
                done++;
            end
            else if (roll < 94)
            begin
                send_item(ACT_UNUSED, 8'($urandom), $urandom);
                done++;
            end
            else
            begin
                send_item(tcw_pkg::ACT_CHAR, tcw_pkg::CHAR_NUL, $urandom);
                done++;
            end
        end
    endtask

    initial
    begin
        logic [3:0] fg;
        logic [3:0] bg;
        board = new();
        rst_n = 1'b0;
        push = 1'b0;
        action = tcw_pkg::ACT_CHAR;
        char_code = tcw_pkg::CHAR_NUL;
        value = 32'd0;
        pop = 1'b0;
        cfg_we = 1'b0;
        cfg_index = tcw_pkg::REG_FG_COLOR;
        cfg_wdata = 4'd0;
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        color_settings = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: begin fg = 4'h0; bg = 4'hF; end
                1: begin fg = 4'hF; bg = 4'h0; end
                2: begin fg = 4'h0; bg = 4'h0; end
                3: begin fg = 4'hF; bg = 4'hF; end
                default: begin fg = 4'($urandom); bg = 4'($urandom); end
            endcase
            write_color(tcw_pkg::REG_FG_COLOR, fg);
            write_color(tcw_pkg::REG_BG_COLOR, bg);
            color_settings++;
            send_gaps = (p == 1) ? 1'b0 : 1'($urandom_range(0, 1));
            run_random(PHASE_ITEMS);
            drain();
        end

        $display("covered %0d char, %0d newline, %0d hex, %0d decimal, %0d ignored items",
                 board.n_char, board.n_newline, board.n_hex, board.n_dec, board.n_ignored);
        $display("checked %0d cell writes across %0d color settings, %0d mismatches",
                 board.cells_checked, color_settings, board.errors);
        if (board.errors == 0 && board.pending_cells.size() == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

    initial
    begin
        int                         gap;
        logic                       e;
        logic [tcw_pkg::ADDR_W-1:0] a;
        logic [15:0]                w;
        logic                       l;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = recv_gaps ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do
            begin
                @(negedge clk);
                e = empty;
                a = cell_address;
                w = cell_word;
                l = last;
                @(posedge clk);
            end
            while (e);
            board.check_cell(a, w, l);
            if ($urandom_range(0, 29) == 0)
            begin
                recv_gaps = ~recv_gaps;
            end
        end
    end

    initial
    begin
        int stalled;
        stalled = 0;
        wait (rst_n === 1'b1);
        while (stalled < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((push && !full) || (pop && !empty) || cfg_we)
            begin
                stalled = 0;
            end
            else
            begin
                stalled++;
            end
        end
        $display("testbench failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/tcw_pkg.sv
rtl/core/tcw_front.sv
rtl/core/tcw_back.sv
rtl/core/text_console_cell_writer_core.sv
sim/testbench.sv
